/* hdl/fds_pkg.sv */
// Shared types, widths and codes of the frame difference segment renderer.
`default_nettype none

package fds_pkg;

  // Field widths of the input and result words.
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned BYTE_INDEX_W = 10;
  localparam int unsigned VALUE_W      = 8;
  localparam int unsigned PAGE_NUM_W   = 3;
  localparam int unsigned START_COL_W  = 7;
  localparam int unsigned HALF_SEG_W   = 64;

  // Geometry of the frame store.
  localparam int unsigned PAGE_ROWS   = 8;
  localparam int unsigned SEG_BYTES   = 16;
  localparam int unsigned LANE_W      = 4;
  localparam int unsigned SEG_DATA_W  = SEG_BYTES * VALUE_W;
  localparam int unsigned MAX_PAGE_W  = 4;
  localparam int unsigned MAX_SEG_W   = 4;

  // Defaults of the top-level parameters.
  localparam int unsigned DEF_SCREEN_COLUMNS = 128;
  localparam int unsigned DEF_SCREEN_ROWS    = 64;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Item kinds as they arrive on the input channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_RENDER = 2'd2
  } kind_e;

  // Operations handed from the front to the back.
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_RENDER = 2'd2
  } op_e;

  // One decoded command in the queue.
  typedef struct packed {
    op_e                   op;
    logic [MAX_PAGE_W-1:0] page;
    logic [MAX_SEG_W-1:0]  seg;
    logic [LANE_W-1:0]     lane;
    logic [VALUE_W-1:0]    value;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/fds_if.sv */
// Channel interfaces for the input words and the result words.
`default_nettype none

interface fds_in_if;
  import fds_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [BYTE_INDEX_W-1:0] byte_index;
  logic [VALUE_W-1:0]      byte_value;

  modport source (output valid, kind, byte_index, byte_value, input ready);
  modport sink   (input valid, kind, byte_index, byte_value, output ready);
endinterface

interface fds_out_if;
  import fds_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [PAGE_NUM_W-1:0]  page_number;
  logic [START_COL_W-1:0] start_column;
  logic [HALF_SEG_W-1:0]  segment_low;
  logic [HALF_SEG_W-1:0]  segment_high;
  logic                   final_segment;

  modport source (output valid, page_number, start_column, segment_low, segment_high,
                  final_segment, input ready);
  modport sink   (input valid, page_number, start_column, segment_low, segment_high,
                  final_segment, output ready);
endinterface

`default_nettype wire

/* hdl/fds_front.sv */
// Front end: accepts input words, splits byte addresses into page and column, issues commands.
`default_nettype none

module fds_front import fds_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int unsigned SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fds_in_if.sink   in_i,
  input  logic     hold_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output cmd_t     push_cmd_o
);

  localparam int unsigned PAGE_COUNT  = SCREEN_ROWS / PAGE_ROWS;
  localparam int unsigned FRAME_BYTES = SCREEN_COLUMNS * PAGE_COUNT;
  localparam int unsigned SEGS        = SCREEN_COLUMNS / SEG_BYTES;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / SCREEN_COLUMNS;
  localparam int unsigned PROD_W      = BYTE_INDEX_W + RECIP_SHIFT;
  localparam int unsigned REM_W       = $clog2(2 * SCREEN_COLUMNS);
  localparam int unsigned BASE_W      = BYTE_INDEX_W + REM_W;

  logic                    a_valid_q;
  logic [KIND_W-1:0]       a_kind_q;
  logic [BYTE_INDEX_W-1:0] a_idx_q;
  logic [VALUE_W-1:0]      a_value_q;
  logic [BYTE_INDEX_W-1:0] a_qest_q;
  logic [BYTE_INDEX_W-1:0] qest_d;
  logic [PROD_W-1:0]       prod;
  logic [BASE_W-1:0]       base;
  logic [BASE_W-1:0]       diff;
  logic [REM_W-1:0]        rem;
  logic [REM_W-1:0]        col;
  logic                    corr;
  logic [BYTE_INDEX_W-1:0] page;
  logic                    in_range;
  logic                    seg_ok;
  logic                    need_push;
  logic                    a_done;
  logic                    a_take;

  // Estimate of the page by multiplying with the reciprocal of the width; may be one low.
  assign prod   = PROD_W'(in_i.byte_index) * PROD_W'(RECIP);
  assign qest_d = BYTE_INDEX_W'(prod >> RECIP_SHIFT);

  // Remainder and one correction step give the exact page and column.
  assign base = BASE_W'(a_qest_q) * BASE_W'(SCREEN_COLUMNS);
  assign diff = BASE_W'(a_idx_q) - base;
  assign rem  = REM_W'(diff);
  assign corr = (rem >= REM_W'(SCREEN_COLUMNS));
  assign col  = corr ? (rem - REM_W'(SCREEN_COLUMNS)) : rem;
  assign page = a_qest_q + BYTE_INDEX_W'(corr);

  // Writes outside the frame or into a partial segment are dropped here.
  assign in_range = (32'(a_idx_q) < FRAME_BYTES);
  assign seg_ok   = (32'(col) < SEGS * SEG_BYTES);

  // Build the command; unused kinds issue nothing.
  always_comb begin
    need_push        = 1'b0;
    push_cmd_o.op    = OP_WRITE;
    push_cmd_o.page  = MAX_PAGE_W'(page);
    push_cmd_o.seg   = MAX_SEG_W'(col >> LANE_W);
    push_cmd_o.lane  = col[LANE_W-1:0];
    push_cmd_o.value = a_value_q;
    unique case (a_kind_q)
      KIND_WRITE: begin
        need_push = in_range && seg_ok;
      end
      KIND_CLEAR: begin
        need_push     = 1'b1;
        push_cmd_o.op = OP_CLEAR;
      end
      KIND_RENDER: begin
        need_push     = 1'b1;
        push_cmd_o.op = OP_RENDER;
      end
      default: begin
        need_push = 1'b0;
      end
    endcase
  end

  assign push_valid_o = a_valid_q && need_push;
  assign a_done       = !need_push || push_ready_i;
  assign in_i.ready   = !hold_i && (!a_valid_q || a_done);
  assign a_take       = in_i.valid && in_i.ready;

  // Stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_take) begin
      a_valid_q <= 1'b1;
    end else if (a_done) begin
      a_valid_q <= 1'b0;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (a_take) begin
      a_kind_q  <= in_i.kind;
      a_idx_q   <= in_i.byte_index;
      a_value_q <= in_i.byte_value;
      a_qest_q  <= qest_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/fds_queue.sv */
// Short command queue that decouples the front end from the render engine.
`default_nettype none

module fds_queue import fds_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/fds_back.sv */
// Back end: frame store memory, clearing sweeps and the segment compare walk.
`default_nettype none

module fds_back import fds_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int unsigned SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  cmd_t      pop_cmd_i,
  output logic      init_busy_o,
  fds_out_if.source out_o
);

  localparam int unsigned PAGE_COUNT = SCREEN_ROWS / PAGE_ROWS;
  localparam int unsigned SEGS       = SCREEN_COLUMNS / SEG_BYTES;
  localparam int unsigned PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned SEG_W      = (SEGS > 1) ? $clog2(SEGS) : 1;
  localparam int unsigned ROW_W      = PAGE_W + SEG_W;
  localparam int unsigned ADDR_W     = ROW_W + 1;
  localparam int unsigned MEM_ROWS   = 1 << ADDR_W;

  typedef enum logic [5:0] {
    ST_INIT    = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_CLEAR   = 6'b000100,
    ST_READ    = 6'b001000,
    ST_COMPARE = 6'b010000,
    ST_FLUSH   = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  logic [ADDR_W-1:0]      sweep_q, sweep_d;
  logic [PAGE_W-1:0]      page_q, page_d;
  logic [SEG_W-1:0]       seg_q, seg_d;
  logic                   active_q, active_d;
  logic                   held_valid_q, held_valid_d;
  logic [PAGE_W-1:0]      held_page_q;
  logic [SEG_W-1:0]       held_seg_q;
  logic [SEG_DATA_W-1:0]  held_data_q;
  logic [SEG_DATA_W-1:0]  rd_act_q;
  logic [SEG_DATA_W-1:0]  rd_prev_q;
  logic                   out_valid_q, out_valid_d;
  logic [PAGE_NUM_W-1:0]  out_page_q;
  logic [START_COL_W-1:0] out_col_q;
  logic [SEG_DATA_W-1:0]  out_data_q;
  logic                   out_final_q, out_final_d;
  logic [SEG_DATA_W-1:0]  mem_q [MEM_ROWS];

  logic                   wr_en;
  logic                   wr_all;
  logic [ADDR_W-1:0]      wr_addr;
  logic [LANE_W-1:0]      wr_lane;
  logic [VALUE_W-1:0]     wr_byte;
  logic                   rd_en;
  logic                   held_load;
  logic                   out_load;
  logic                   slot_free;
  logic                   differ;
  logic                   last_seg;

  assign slot_free   = !out_valid_q || out_o.ready;
  assign differ      = (rd_act_q != rd_prev_q);
  assign last_seg    = (page_q == PAGE_W'(PAGE_COUNT - 1)) && (seg_q == SEG_W'(SEGS - 1));
  assign init_busy_o = (state_q == ST_INIT);

  // Sequencer for the reset sweep, writes, clears and the render walk.
  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    page_d       = page_q;
    seg_d        = seg_q;
    active_d     = active_q;
    held_valid_d = held_valid_q;
    wr_en        = 1'b0;
    wr_all       = 1'b0;
    wr_addr      = '0;
    wr_lane      = '0;
    wr_byte      = '0;
    rd_en        = 1'b0;
    held_load    = 1'b0;
    out_load     = 1'b0;
    out_final_d  = 1'b0;
    pop_ready_o  = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_all  = 1'b1;
        wr_addr = sweep_q;
        sweep_d = sweep_q + 1'b1;
        if (&sweep_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          unique case (pop_cmd_i.op)
            OP_WRITE: begin
              wr_en   = 1'b1;
              wr_addr = {active_q, pop_cmd_i.page[PAGE_W-1:0], pop_cmd_i.seg[SEG_W-1:0]};
              wr_lane = pop_cmd_i.lane;
              wr_byte = pop_cmd_i.value;
            end
            OP_CLEAR: begin
              sweep_d = '0;
              state_d = ST_CLEAR;
            end
            OP_RENDER: begin
              page_d  = '0;
              seg_d   = '0;
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_all  = 1'b1;
        wr_addr = {active_q, sweep_q[ROW_W-1:0]};
        sweep_d = sweep_q + 1'b1;
        if (&sweep_q[ROW_W-1:0]) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_COMPARE;
      end
      ST_COMPARE: begin
        // A new changed segment pushes the held one out, so it waits for a free slot.
        if (!(differ && held_valid_q && !slot_free)) begin
          if (differ) begin
            held_load    = 1'b1;
            held_valid_d = 1'b1;
            out_load     = held_valid_q;
          end
          if (last_seg) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_READ;
            if (seg_q == SEG_W'(SEGS - 1)) begin
              seg_d  = '0;
              page_d = page_q + 1'b1;
            end else begin
              seg_d = seg_q + 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        // The segment still held is the last one of this render.
        if (!held_valid_q) begin
          active_d = ~active_q;
          state_d  = ST_IDLE;
        end else if (slot_free) begin
          out_load     = 1'b1;
          out_final_d  = 1'b1;
          held_valid_d = 1'b0;
          active_d     = ~active_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      sweep_q      <= '0;
      page_q       <= '0;
      seg_q        <= '0;
      active_q     <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      page_q       <= page_d;
      seg_q        <= seg_d;
      active_q     <= active_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Held segment and output word.
  always_ff @(posedge clk_i) begin
    if (held_load) begin
      held_page_q <= page_q;
      held_seg_q  <= seg_q;
      held_data_q <= rd_act_q;
    end
    if (out_load) begin
      out_page_q  <= PAGE_NUM_W'(held_page_q);
      out_col_q   <= START_COL_W'({held_seg_q, {LANE_W{1'b0}}});
      out_data_q  <= held_data_q;
      out_final_q <= out_final_d;
    end
  end

  // Frame store write port: one byte lane or a whole segment row of zeros.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (wr_all) begin
        mem_q[wr_addr] <= '0;
      end else begin
        mem_q[wr_addr][VALUE_W*wr_lane +: VALUE_W] <= wr_byte;
      end
    end
  end

  // Frame store read ports: the same segment row from both halves.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_act_q  <= mem_q[{active_q, page_q, seg_q}];
      rd_prev_q <= mem_q[{~active_q, page_q, seg_q}];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.page_number   = out_page_q;
  assign out_o.start_column  = out_col_q;
  assign out_o.segment_low   = out_data_q[HALF_SEG_W-1:0];
  assign out_o.segment_high  = out_data_q[SEG_DATA_W-1:HALF_SEG_W];
  assign out_o.final_segment = out_final_q;

`ifndef ASSERT_OFF
  a_idle_nothing_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !held_valid_q)
    else $error("segment still held while the engine is idle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("output word overwritten before it was taken");

  a_swap_at_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q != $past(active_q)) |-> ($past(state_q) == ST_FLUSH))
    else $error("active buffer swapped outside the end of a render");

  a_final_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_final_d) |=> !held_valid_q)
    else $error("segment still held after the final word");
`endif

endmodule

`default_nettype wire

/* hdl/frame_diff_segment_render.sv */
// Top level of the frame difference segment renderer.
//
// Input channel in_i carries one word per item: kind selects a byte write into the
// active buffer, a clear of the active buffer, or a render. Output channel out_o
// carries one word per changed 16-byte segment with its page, start column and data;
// final_segment marks the last word of a render, after which the buffers swap.
// Byte writes are accepted one per cycle while in_i.ready is high, and pass through the
// front stage register and the command queue to the store. A clear is taken from the
// queue and then zeroes each segment row of the active buffer in turn. A render walks
// the segments in order, each through the memory read and the compare, then a closing
// flush step, and is slowed while out_o stalls; a stalled receiver holds the word in
// the output register and the walk waits on it. Items following a clear or render
// queue up in a four-entry command queue. After reset a clearing pass zeroes both
// buffers, one segment row per cycle; in_i.ready stays low until it has finished.
`default_nettype none

module frame_diff_segment_render import fds_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int unsigned SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fds_in_if.sink    in_i,
  fds_out_if.source out_o
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;
  logic init_busy;

  // Decode and address split.
  fds_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .hold_i       (init_busy),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // Command queue.
  fds_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // Frame store and render engine.
  fds_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .init_busy_o (init_busy),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_frame_diff_segment_render.sv */
// Self-checking testbench for the frame difference segment renderer.
`default_nettype none

module tb_frame_diff_segment_render;
  import fds_pkg::*;

  // Geometry at the default parameters of the block.
  localparam int unsigned PAGES         = DEF_SCREEN_ROWS / PAGE_ROWS;
  localparam int unsigned FRAME_BYTES   = DEF_SCREEN_COLUMNS * PAGES;
  localparam int unsigned SEGS_PER_PAGE = DEF_SCREEN_COLUMNS / SEG_BYTES;
  localparam int unsigned SEG_COUNT     = PAGES * SEGS_PER_PAGE;

  // The one input kind that the block ignores.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Run control.
  localparam int unsigned ITEM_TARGET = 420;
  localparam int unsigned TAIL_CYCLES = 700;
  localparam int unsigned CYCLE_LIMIT = 1_200_000;

  // One input word waiting to be sent, with its lead-in gap.
  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic [BYTE_INDEX_W-1:0] index;
    logic [VALUE_W-1:0]      value;
    int unsigned             gap;
    bit                      drain;
  } frame_cmd_t;

  // One changed segment as it should appear on the output channel.
  typedef struct packed {
    logic [PAGE_NUM_W-1:0]  page;
    logic [START_COL_W-1:0] col;
    logic [HALF_SEG_W-1:0]  lo;
    logic [HALF_SEG_W-1:0]  hi;
    logic                   last_seg;
  } seg_word_t;

  logic clk_i;
  logic rst_ni;

  fds_in_if  in_if ();
  fds_out_if out_if ();

  frame_diff_segment_render dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of both frame buffers and of the active-buffer flag.
  logic [VALUE_W-1:0] frame_mem [0:1][0:FRAME_BYTES-1];
  bit                 shown;

  frame_cmd_t  cmd_backlog [$];
  seg_word_t   seg_expect [$];
  int unsigned fault_count;
  int unsigned planned_items;
  int unsigned cycle_count;
  bit          tx_eager;

  // Driver and monitor working state.
  int unsigned idle_run;
  frame_cmd_t  head_cmd;
  int unsigned rx_hold;
  int unsigned rx_next;
  int unsigned rx_words;
  bit          rx_eager;

  // Clock and the single reset at the start.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Print one line per mismatch and keep count.
  task automatic report_fault(input string msg);
    fault_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Work out what one accepted input word does to the frame store and which
  // segment words it should produce.
  task automatic apply_frame_cmd(input logic [KIND_W-1:0] kind,
                                 input logic [BYTE_INDEX_W-1:0] index,
                                 input logic [VALUE_W-1:0] value);
    int unsigned pg, sg, b, base;
    bit          other_half, differs, have_held;
    seg_word_t   held;
    other_half = ~shown;
    have_held  = 1'b0;
    held       = '0;
    case (kind)
      KIND_WRITE: begin
        if (index < FRAME_BYTES) frame_mem[shown][index] = value;
      end
      KIND_CLEAR: begin
        for (b = 0; b < FRAME_BYTES; b++) frame_mem[shown][b] = '0;
      end
      KIND_RENDER: begin
        for (pg = 0; pg < PAGES; pg++) begin
          for (sg = 0; sg < SEGS_PER_PAGE; sg++) begin
            base    = pg * DEF_SCREEN_COLUMNS + sg * SEG_BYTES;
            differs = 1'b0;
            for (b = 0; b < SEG_BYTES; b++) begin
              if (frame_mem[shown][base+b] != frame_mem[other_half][base+b]) differs = 1'b1;
            end
            if (differs) begin
              // A word is only known not to be the last once another follows it.
              if (have_held) seg_expect.push_back(held);
              held.page     = PAGE_NUM_W'(pg);
              held.col      = START_COL_W'(sg * SEG_BYTES);
              for (b = 0; b < 8; b++) begin
                held.lo[8*b +: 8] = frame_mem[shown][base+b];
                held.hi[8*b +: 8] = frame_mem[shown][base+8+b];
              end
              held.last_seg = 1'b0;
              have_held     = 1'b1;
            end
          end
        end
        if (have_held) begin
          held.last_seg = 1'b1;
          seg_expect.push_back(held);
        end
        shown = other_half;
      end
      default: begin
      end
    endcase
  endtask

  // Compare a received segment word with the oldest one expected.
  task automatic check_seg_word();
    seg_word_t want;
    if (seg_expect.size() == 0) begin
      report_fault($sformatf("unexpected word page %0d column %0d",
                             out_if.page_number, out_if.start_column));
    end else begin
      want = seg_expect.pop_front();
      if (out_if.page_number !== want.page)
        report_fault($sformatf("page_number got %0d want %0d",
                               out_if.page_number, want.page));
      if (out_if.start_column !== want.col)
        report_fault($sformatf("start_column got %0d want %0d (page %0d)",
                               out_if.start_column, want.col, want.page));
      if (out_if.segment_low !== want.lo)
        report_fault($sformatf("segment_low got %h want %h (page %0d column %0d)",
                               out_if.segment_low, want.lo, want.page, want.col));
      if (out_if.segment_high !== want.hi)
        report_fault($sformatf("segment_high got %h want %h (page %0d column %0d)",
                               out_if.segment_high, want.hi, want.page, want.col));
      if (out_if.final_segment !== want.last_seg)
        report_fault($sformatf("final_segment got %b want %b (page %0d column %0d)",
                               out_if.final_segment, want.last_seg, want.page, want.col));
    end
  endtask

  // Queue one input word; its gap follows the current burst style.
  task automatic add_cmd(input logic [KIND_W-1:0] kind,
                         input logic [BYTE_INDEX_W-1:0] index,
                         input logic [VALUE_W-1:0] value,
                         input bit drain);
    frame_cmd_t c;
    c.kind  = kind;
    c.index = index;
    c.value = value;
    c.gap   = tx_eager ? 0 : $urandom_range(0, 4);
    c.drain = drain;
    cmd_backlog.push_back(c);
    if (kind != KIND_UNUSED) planned_items++;
  endtask

  // Pixel bytes with the all-clear and all-set patterns favoured.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VALUE_W'($urandom_range(0, 255));
  endfunction

  // Clear, a nonzero byte in every segment, render, clear and a second render: the second
  // sees every segment of the swept buffer differ, giving the longest possible run of words.
  task automatic add_full_sweep();
    int unsigned s;
    add_cmd(KIND_CLEAR, '0, '0, 1'b0);
    for (s = 0; s < SEG_COUNT; s++)
      add_cmd(KIND_WRITE, BYTE_INDEX_W'(s * SEG_BYTES + $urandom_range(0, SEG_BYTES - 1)),
              VALUE_W'($urandom_range(1, 255)), 1'b0);
    add_cmd(KIND_RENDER, '0, '0, 1'b0);
    add_cmd(KIND_CLEAR, '0, '0, 1'b0);
    add_cmd(KIND_RENDER, '0, '0, 1'b0);
  endtask

  // Stimulus: a directed opening, then random frames with some noise mixed in.
  initial begin
    int unsigned pick, n, i;
    bit          swept;
    fault_count   = 0;
    planned_items = 0;
    shown         = 1'b0;
    swept         = 1'b0;
    for (i = 0; i < FRAME_BYTES; i++) begin
      frame_mem[0][i] = '0;
      frame_mem[1][i] = '0;
    end

    // Render straight after reset: nothing differs, but the buffers still swap.
    tx_eager = 1'b0;
    add_cmd(KIND_RENDER, '0, '0, 1'b0);
    // Corner addresses and alternating bit patterns in both fields.
    add_cmd(KIND_WRITE, 10'd0, 8'hFF, 1'b0);
    add_cmd(KIND_WRITE, 10'd1023, 8'h80, 1'b0);
    add_cmd(KIND_WRITE, 10'h155, 8'h55, 1'b0);
    add_cmd(KIND_WRITE, 10'h2AA, 8'hAA, 1'b0);
    // A byte written and then restored leaves its segment unchanged.
    add_cmd(KIND_WRITE, 10'd16, 8'h01, 1'b0);
    add_cmd(KIND_WRITE, 10'd16, 8'h00, 1'b0);
    // The unused kind must change nothing.
    add_cmd(KIND_UNUSED, 10'd1023, 8'hFF, 1'b0);
    add_cmd(KIND_RENDER, '0, '0, 1'b0);
    // Back on the untouched buffer: the same segments differ, now carrying zeros.
    add_cmd(KIND_RENDER, '0, '0, 1'b0);
    // Clear the written buffer while every word is out, then render with no change.
    add_cmd(KIND_CLEAR, '0, '0, 1'b1);
    add_cmd(KIND_RENDER, '0, '0, 1'b0);
    tx_eager = 1'b1;
    add_cmd(KIND_WRITE, 10'd100, 8'h3C, 1'b0);
    add_cmd(KIND_RENDER, '0, '0, 1'b0);
    add_cmd(KIND_CLEAR, '0, '0, 1'b0);
    add_cmd(KIND_RENDER, '0, '0, 1'b0);

    while (planned_items < ITEM_TARGET) begin
      tx_eager = ($urandom_range(0, 3) == 0);
      pick     = $urandom_range(0, 11);
      if (pick == 11 && !swept) begin
        add_full_sweep();
        swept = 1'b1;
      end else if (pick == 8) begin
        // Noise: any kind, any address.
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
          add_cmd(KIND_W'($urandom_range(0, 3)), BYTE_INDEX_W'($urandom_range(0, 1023)),
                  pick_value(), 1'b0);
      end else if (pick == 9) begin
        // Back-to-back renders and renders right after a clear.
        add_cmd($urandom_range(0, 1) ? KIND_RENDER : KIND_CLEAR, '0, '0, 1'b0);
        add_cmd(KIND_RENDER, BYTE_INDEX_W'($urandom_range(0, 1023)), pick_value(), 1'b0);
      end else begin
        // A frame: optionally a clear, a burst of writes, then a render.
        if ($urandom_range(0, 5) == 0) add_cmd(KIND_CLEAR, '0, '0, 1'b0);
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++)
          add_cmd(KIND_WRITE, BYTE_INDEX_W'($urandom_range(0, 1023)), pick_value(),
                  (i == 0) && ($urandom_range(0, 5) == 0));
        add_cmd(KIND_RENDER, '0, '0, 1'b0);
      end
    end

    // Wait for every word to be sent and every segment word to come back.
    @(posedge rst_ni);
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || in_if.valid || seg_expect.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fault_count == 0 && seg_expect.size() == 0) begin
      $display("tb_frame_diff_segment_render: clean");
    end else begin
      $display("tb_frame_diff_segment_render: errors");
    end
    $finish;
  end

  // Driver: present queued words, honouring their gaps and drain requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.kind       <= KIND_WRITE;
      in_if.byte_index <= '0;
      in_if.byte_value <= '0;
      idle_run         <= 0;
    end else begin
      if (in_if.valid && in_if.ready)
        apply_frame_cmd(in_if.kind, in_if.byte_index, in_if.byte_value);
      if (in_if.valid && !in_if.ready) begin
        // Word still on offer: hold it.
      end else if (cmd_backlog.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (cmd_backlog[0].drain && seg_expect.size() != 0) begin
        in_if.valid <= 1'b0;
      end else if (idle_run < cmd_backlog[0].gap) begin
        in_if.valid <= 1'b0;
        idle_run    <= idle_run + 1;
      end else begin
        head_cmd          = cmd_backlog.pop_front();
        in_if.valid      <= 1'b1;
        in_if.kind       <= head_cmd.kind;
        in_if.byte_index <= head_cmd.index;
        in_if.byte_value <= head_cmd.value;
        idle_run         <= 0;
      end
    end
  end

  // Monitor: check each accepted segment word and stall the channel at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b1;
      rx_hold      <= 0;
      rx_words     <= 0;
      rx_eager     <= 1'b1;
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_seg_word();
        rx_next  = rx_eager ? 0 : $urandom_range(0, 4);
        rx_words <= rx_words + 1;
        if (rx_words % 32 == 31) rx_eager <= ($urandom_range(0, 3) == 0);
      end else begin
        rx_next = (rx_hold == 0) ? 0 : rx_hold - 1;
      end
      rx_hold      <= rx_next;
      out_if.ready <= (rx_next == 0);
    end
  end

  // Guard against a hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_frame_diff_segment_render: errors");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

`default_nettype wire

/* sim.f */
hdl/fds_pkg.sv
hdl/fds_if.sv
hdl/fds_front.sv
hdl/fds_queue.sv
hdl/fds_back.sv
hdl/frame_diff_segment_render.sv
tb/sv/tb_frame_diff_segment_render.sv
